@@ sv/mio0_pkg.sv @@
// Shared types and constants for the MIO0 LZ decompressor.
// No dependencies; imported by mio0_outq, the top level and the testbench, not by mio0_ram.
package mio0_pkg;

   localparam int HISTORY_DEPTH = 4096;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int LEN_BIAS      = 3;
   localparam int RUN_W         = 5;   // holds the longest run, 18
   localparam int COUNT_W       = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN
   } state_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERRUN  = 2'd1,
      ERR_DISTANCE = 2'd2,
      ERR_LAYOUT   = 2'd3
   } err_type;

   // source of one output byte
   typedef enum logic [1:0] {
      KIND_LIT,
      KIND_HIST,
      KIND_ERR
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       file_done;
      err_type    error_code;
   } rsp_type;

endpackage

@@ sv/mio0_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module mio0_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mio0_outq.sv @@
// Two-entry response queue that decouples the copy pipe from rsp_stall.
// Depends on mio0_pkg (rsp_type).
module mio0_outq import mio0_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   input  logic       stall,
   output logic       valid,
   output rsp_type    head,
   output logic [1:0] count
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign valid = (count_ff != 2'd0);
   assign pop   = valid && !stall;
   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/mio0_lz_decompressor.sv @@
// Top level of the MIO0 LZ decompressor: token check, copy sequencer, history.
// Depends on mio0_pkg, mio0_ram and mio0_outq.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall | mode, literal_byte, ref_word, final_token
//  rsp     | out       | rsp_valid/rsp_stall | out_byte, run_last, file_done, error_code
//  csr     | in        | csr_wr_en           | csr_wr_data -> output_length
//
// A token is accepted, then checked, then its output bytes are issued (one byte for a
// literal, 3..18 for a reference, one for an error). The byte rate is set by the
// single read port of the 4096-byte history RAM.
// Synchronous active-high reset clears the sequencer, the byte count, the queue and sets
// output_length to 1; the history RAM is not cleared. rsp_stall holds bytes in a two-entry
// queue; issue of new history reads pauses once that queue would fill.
module mio0_lz_decompressor import mio0_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_literal_byte,
   input  logic [15:0] req_ref_word,
   input  logic        req_final_token,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_file_done,
   output logic [1:0]  rsp_error_code,
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   length_ff;
   logic [COUNT_W-1:0]   bytes_out_ff, bytes_out_in;

   // request latched at accept
   logic                 tok_mode_ff;
   logic                 tok_final_ff;
   logic [7:0]           tok_lit_ff;
   logic [15:0]          tok_word_ff;

   // result of the check cycle
   logic [RUN_W-1:0]     rem_ff, rem_in;
   err_type              err_ff;
   logic                 done_ff;

   // control strobes from the FSM output block
   logic                 tok_load;
   logic                 chk_load;
   logic                 issue_en;

   // --------------------------------------------------------- token check
   logic [RUN_W-1:0]     run_len;
   logic [COUNT_W:0]     end_sum;
   logic [HIST_AW:0]     ref_dist;
   logic                 end_hit;
   err_type              chk_err;

   always_comb begin
      run_len  = tok_mode_ff ? RUN_W'(1)
                             : (RUN_W'(tok_word_ff[15:12]) + RUN_W'(LEN_BIAS));
      end_sum  = {1'b0, bytes_out_ff} + (COUNT_W+1)'(run_len);
      ref_dist = {1'b0, tok_word_ff[HIST_AW-1:0]} + (HIST_AW+1)'(1);
      end_hit  = (end_sum == {1'b0, length_ff});
      // overrun first, then distance, then a short layout
      priority if (end_sum > {1'b0, length_ff}) begin
         chk_err = ERR_OVERRUN;
      end else if (!tok_mode_ff && (bytes_out_ff < COUNT_W'(ref_dist))) begin
         chk_err = ERR_DISTANCE;
      end else if (tok_final_ff && !end_hit) begin
         chk_err = ERR_LAYOUT;
      end else begin
         chk_err = ERR_NONE;
      end
   end

   // ------------------------------------------------------------ issue side
   logic                 issue_last;
   kind_type             issue_kind;
   logic [HIST_AW-1:0]   dst_addr;
   logic [HIST_AW-1:0]   src_addr;
   logic                 can_issue;
   logic [1:0]           q_count;
   logic                 q_pop;
   logic                 b_valid_ff;

   assign dst_addr = bytes_out_ff[HIST_AW-1:0];
   // distance is the field plus one
   assign src_addr = dst_addr - tok_word_ff[HIST_AW-1:0] - HIST_AW'(1);

   always_comb begin
      issue_last = (err_ff != ERR_NONE) || (rem_ff == RUN_W'(1));
      priority if (err_ff != ERR_NONE) begin
         issue_kind = KIND_ERR;
      end else if (tok_mode_ff) begin
         issue_kind = KIND_LIT;
      end else begin
         issue_kind = KIND_HIST;
      end
   end

   // a new byte may start only if the queue has room for it when it lands,
   // counting the byte still in flight
   assign q_pop     = rsp_valid && !rsp_stall;
   assign can_issue = ({1'b0, q_count} + {2'b0, b_valid_ff}) <= (3'd1 + {2'b0, q_pop});

   // ------------------------------------------------------- data stage (B)
   kind_type             b_kind_ff;
   logic [HIST_AW-1:0]   b_dst_ff;
   logic                 b_last_ff;
   logic                 b_done_ff;
   err_type              b_err_ff;
   logic [7:0]           b_lit_ff;
   logic                 fwd_ff, fwd_in;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           b_byte;
   logic [7:0]           ram_rdata;
   logic                 b_write;
   rsp_type              push_data;
   rsp_type              q_head;

   always_comb begin
      unique case (b_kind_ff)
         KIND_LIT:  b_byte = b_lit_ff;
         KIND_HIST: b_byte = fwd_ff ? fwd_data_ff : ram_rdata;
         default:   b_byte = 8'd0;
      endcase
   end

   assign b_write = b_valid_ff && (b_kind_ff != KIND_ERR);

   // distance one: the read is issued at the same edge the previous byte is
   // written, so the RAM would return stale data; take the byte from stage B
   assign fwd_in = b_write && (b_dst_ff == src_addr);

   always_comb begin
      push_data.out_byte   = b_byte;
      push_data.run_last   = b_last_ff;
      push_data.file_done  = b_done_ff;
      push_data.error_code = b_err_ff;
   end

   // ------------------------------------------------------------------ FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) begin
            state_in = ST_CHECK;
         end
         ST_CHECK: state_in = ST_RUN;
         ST_RUN:   if (issue_en && issue_last) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      tok_load  = (state_ff == ST_IDLE) && req_valid;
      chk_load  = (state_ff == ST_CHECK);
      issue_en  = (state_ff == ST_RUN) && can_issue;
   end

   // --------------------------------------------------------- next values
   always_comb begin
      bytes_out_in = bytes_out_ff;
      if (issue_en) begin
         if ((err_ff != ERR_NONE) || (issue_last && done_ff)) begin
            bytes_out_in = '0;   // error or file complete: new file
         end else begin
            bytes_out_in = bytes_out_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (chk_load) begin
         rem_in = run_len;
      end else if (issue_en) begin
         rem_in = rem_ff - RUN_W'(1);
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= COUNT_W'(1);
         bytes_out_ff <= '0;
         b_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bytes_out_ff <= bytes_out_in;
         b_valid_ff   <= issue_en;
         if (csr_wr_en) begin
            length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (tok_load) begin
         tok_mode_ff  <= req_mode;
         tok_final_ff <= req_final_token;
         tok_lit_ff   <= req_literal_byte;
         tok_word_ff  <= req_ref_word;
      end
      if (chk_load) begin
         err_ff  <= chk_err;
         done_ff <= end_hit;
      end
      if (issue_en) begin
         b_kind_ff   <= issue_kind;
         b_dst_ff    <= dst_addr;
         b_last_ff   <= issue_last;
         b_done_ff   <= issue_last && done_ff && (err_ff == ERR_NONE);
         b_err_ff    <= err_ff;
         b_lit_ff    <= tok_lit_ff;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= b_byte;
      end
   end

   // -------------------------------------------------------- submodules
   mio0_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (b_write),
      .wr_addr (b_dst_ff),
      .wr_data (b_byte),
      .rd_en   (issue_en && (issue_kind == KIND_HIST)),
      .rd_addr (src_addr),
      .rd_data (ram_rdata)
   );

   mio0_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid_ff),
      .push_data (push_data),
      .stall     (rsp_stall),
      .valid     (rsp_valid),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_out_byte   = q_head.out_byte;
   assign rsp_run_last   = q_head.run_last;
   assign rsp_file_done  = q_head.file_done;
   assign rsp_error_code = q_head.error_code;

   // ---------------------------------------------------------- assertions
   // the issue throttle must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_count == 2'd2) |-> !(b_valid_ff && !q_pop))
      else $error("response queue overflow");

   // the last byte of a token returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (issue_en && issue_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last byte");

   // an error result is a single zero byte with no completion flag
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_NONE)) |->
         ((rsp_out_byte == 8'd0) && rsp_run_last && !rsp_file_done))
      else $error("malformed error response");

   // the byte count is cleared once a file completes
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (issue_en && issue_last && done_ff) |=> (bytes_out_ff == '0))
      else $error("byte count not cleared at end of file");

endmodule

@@ tb/sv/tb_mio0_lz_decompressor.sv @@
// Testbench for mio0_lz_decompressor: a directed table, then random token streams,
// checked byte by byte against an in-bench token expander or hand-written results.
// Depends on mio0_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_mio0_lz_decompressor import mio0_pkg::*; ();

   localparam logic MODE_LIT    = 1'b1;   // layout bit for a literal byte
   localparam logic MODE_REF    = 1'b0;   // layout bit for a back-reference
   localparam int   CYCLE_LIMIT = 200000;
   localparam int   IDLE_PCT    = 23;     // chance per cycle that a side idles

   // one request as seen on the req_ ports
   typedef struct {
      logic        mode;
      logic [7:0]  lit;
      logic [15:0] word;
      logic        fin;
   } lz_token_type;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      bit           set_len;
      logic [31:0]  new_len;
      lz_token_type tok;
      bit           typed;
      rsp_type      want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [7:0]  req_literal_byte = '0;
   logic [15:0] req_ref_word = '0;
   logic        req_final_token = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_file_done;
   logic [1:0]  rsp_error_code;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // expander state: its own copy of the history, byte count and file length
   logic [7:0]  hist_mem [HISTORY_DEPTH];
   logic [31:0] file_count;
   logic [31:0] file_len;

   rsp_type     model_out[$];     // bytes produced by the last expanded token
   rsp_type     pending_bytes[$]; // expected results still to arrive
   dir_row_type dir_rows[$];

   bit          calm = 1'b0;      // no idling on either side while set
   int          cycle_count = 0;
   int          mismatches = 0;
   int          bytes_checked = 0;
   int          files_done = 0;
   int          error_results = 0;
   int          random_sent = 0;
   int          deepest_count = 0;

   mio0_lz_decompressor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_literal_byte (req_literal_byte),
      .req_ref_word     (req_ref_word),
      .req_final_token  (req_final_token),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_file_done    (rsp_file_done),
      .rsp_error_code   (rsp_error_code),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or missing bytes end the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_bytes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
               $realtime, what, got, want, bytes_checked);
      mismatches++;
   endtask

   // Expands one token into its output bytes, exactly as the block should.
   // Error precedence: overrun, then distance, then short layout.
   function automatic void expand_token(lz_token_type t);
      int unsigned           run_len;
      int unsigned           back;
      longint unsigned       stop;
      err_type               code;
      logic [HIST_AW-1:0]    rd_idx;
      logic [7:0]            b;
      rsp_type               r;
      model_out.delete();
      if (t.mode == MODE_LIT) begin
         run_len = 1;
         back    = 0;
      end else begin
         run_len = t.word[15:12] + LEN_BIAS;
         back    = t.word[11:0] + 1;
      end
      stop = longint'(file_count) + run_len;
      code = ERR_NONE;
      if (stop > longint'(file_len))
         code = ERR_OVERRUN;
      else if (t.mode == MODE_REF && file_count < back)
         code = ERR_DISTANCE;
      else if (t.fin && stop != longint'(file_len))
         code = ERR_LAYOUT;
      if (code != ERR_NONE) begin
         r.out_byte   = 8'h00;
         r.run_last   = 1'b1;
         r.file_done  = 1'b0;
         r.error_code = code;
         model_out.push_back(r);
         file_count = 0;
         return;
      end
      for (int k = 0; k < run_len; k++) begin
         // a distance of 4096 wraps onto the slot about to be overwritten
         rd_idx = file_count[HIST_AW-1:0] - back[HIST_AW-1:0];
         b = (t.mode == MODE_LIT) ? t.lit : hist_mem[rd_idx];
         hist_mem[file_count[HIST_AW-1:0]] = b;
         file_count++;
         r.out_byte   = b;
         r.run_last   = (k == run_len - 1);
         r.file_done  = (file_count == file_len);
         r.error_code = ERR_NONE;
         model_out.push_back(r);
      end
      if (file_count > deepest_count)
         deepest_count = file_count;
      if (file_count == file_len)
         file_count = 0;
   endfunction

   function automatic void add_row(bit set_len, logic [31:0] len, logic mode,
                                   logic [7:0] lit, logic [15:0] word, logic fin,
                                   bit typed, logic [7:0] wb, logic wdone, err_type werr);
      dir_row_type row;
      row.set_len         = set_len;
      row.new_len         = len;
      row.tok.mode        = mode;
      row.tok.lit         = lit;
      row.tok.word        = word;
      row.tok.fin         = fin;
      row.typed           = typed;
      row.want.out_byte   = wb;
      row.want.run_last   = 1'b1;
      row.want.file_done  = wdone;
      row.want.error_code = werr;
      dir_rows.push_back(row);
   endfunction

   // Stop sending and let every expected byte come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Length register is only written with the block idle.
   task automatic set_file_length(logic [31:0] len);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      file_len    = len;
   endtask

   // Presents one request, waits for it to be taken, then queues what it must produce.
   // With typed set, the hand-written byte replaces the expander's (state still advances).
   task automatic send_request(lz_token_type t, bit typed, rsp_type want);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= t.mode;
      req_literal_byte <= t.lit;
      req_ref_word     <= t.word;
      req_final_token  <= t.fin;
      do @(posedge clock); while (req_stall !== 1'b0);
      expand_token(t);
      if (typed)
         pending_bytes.push_back(want);
      else
         foreach (model_out[i]) pending_bytes.push_back(model_out[i]);
   endtask

   // Random token: mostly a legal continuation of the current file, sometimes noise.
   // long_bias favors 18-byte copies so a file grows past the history depth.
   task automatic make_token(int noise_pct, bit long_bias, output lz_token_type t);
      longint unsigned rem;
      int unsigned     span;
      int unsigned     reach;
      int unsigned     run;
      int unsigned     back;
      rem   = (file_count >= file_len) ? 0 : longint'(file_len) - file_count;
      t.lit  = $urandom;
      t.word = $urandom;
      if (rem == 0 || $urandom_range(99) < noise_pct) begin
         t.mode = $urandom_range(1);
         t.fin  = ($urandom_range(3) == 0);
         return;
      end
      span  = (rem > 18) ? 18 : int'(rem);
      reach = (file_count > HISTORY_DEPTH) ? HISTORY_DEPTH : file_count;
      run   = 1;
      if (reach >= 1 && span >= 3 && $urandom_range(99) < (long_bias ? 95 : 55)) begin
         run = (long_bias && $urandom_range(9) != 0) ? span : $urandom_range(span, 3);
         if ($urandom_range(3) == 0)
            back = $urandom_range((reach < 3) ? reach : 3, 1);   // overlapping copy
         else if ($urandom_range(7) == 0)
            back = reach;                                        // farthest legal
         else
            back = $urandom_range(reach, 1);
         t.mode = MODE_REF;
         t.word = {4'(run - LEN_BIAS), 12'(back - 1)};
      end else begin
         t.mode = MODE_LIT;
      end
      t.fin = (run == rem) ? $urandom_range(1) : 1'b0;
   endtask

   // Result side: random stall, then an in-order compare against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_out_byte, 0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
            if (rsp_file_done !== want.file_done)
               report_mismatch("file_done", rsp_file_done, want.file_done);
            if (rsp_error_code !== want.error_code)
               report_mismatch("error_code", rsp_error_code, want.error_code);
         end
         bytes_checked++;
         if (rsp_file_done === 1'b1) files_done++;
         if (rsp_error_code != ERR_NONE) error_results++;
      end
   end

   initial begin : stimulus
      lz_token_type t;
      rsp_type      none;
      logic [31:0]  len;
      int           count;
      int           noise;
      bit           longs;

      none       = '0;
      file_count = 0;
      file_len   = 1;
      foreach (hist_mem[i]) hist_mem[i] = 8'h00;

      // Directed table. Columns: set length, length, mode, literal, ref word, final,
      // typed, byte, done, code. Unused fields carry junk the block must ignore.
      // Right after reset the file length is 1: any single literal completes a file.
      add_row(0, 0, MODE_LIT, 8'hA5, 16'hBEEF, 1, 1, 8'hA5, 1, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h00, 16'hFFFF, 0, 1, 8'h00, 1, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'hFF, 16'h0000, 0, 1, 8'hFF, 1, ERR_NONE);
      // 3-byte copy cannot fit a 1-byte file
      add_row(0, 0, MODE_REF, 8'h5A, 16'h0000, 0, 1, 8'h00, 0, ERR_OVERRUN);
      // zero length: every token overruns
      add_row(1, 32'h0, MODE_LIT, 8'h5A, 16'h1234, 0, 1, 8'h00, 0, ERR_OVERRUN);
      // empty history: distance wins over short layout
      add_row(1, 32'hFFFF_FFFF, MODE_REF, 8'hC3, 16'h0000, 1, 1, 8'h00, 0, ERR_DISTANCE);
      add_row(0, 0, MODE_LIT, 8'h77, 16'h0F0F, 1, 1, 8'h00, 0, ERR_LAYOUT);
      add_row(0, 0, MODE_LIT, 8'h11, 16'h8001, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h22, 16'h4002, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h33, 16'h2003, 0, 0, 0, 0, ERR_NONE);
      // longest run at distance 1: overlapping copy of the last byte
      add_row(0, 0, MODE_REF, 8'hEE, 16'hF000, 0, 0, 0, 0, ERR_NONE);
      // copy from the very first byte of the file
      add_row(0, 0, MODE_REF, 8'h99, 16'h0014, 0, 0, 0, 0, ERR_NONE);
      // farthest distance before the file start
      add_row(0, 0, MODE_REF, 8'h01, 16'h0FFF, 0, 1, 8'h00, 0, ERR_DISTANCE);
      add_row(0, 0, MODE_REF, 8'hFF, 16'hFFFF, 0, 1, 8'h00, 0, ERR_DISTANCE);
      // 8-byte file closed by a final copy
      add_row(1, 32'd8, MODE_LIT, 8'h80, 16'hFFFF, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h7F, 16'h0000, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h01, 16'hAAAA, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'hFE, 16'h5555, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h40, 16'h0101, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_REF, 8'h3C, 16'h0004, 1, 0, 0, 0, ERR_NONE);
      // 3-byte file
      add_row(1, 32'd3, MODE_REF, 8'h00, 16'h0000, 0, 1, 8'h00, 0, ERR_DISTANCE);
      add_row(0, 0, MODE_LIT, 8'h9C, 16'hFFFF, 1, 1, 8'h00, 0, ERR_LAYOUT);
      // overrun wins over distance and short layout
      add_row(0, 0, MODE_REF, 8'h00, 16'h1000, 1, 1, 8'h00, 0, ERR_OVERRUN);
      add_row(0, 0, MODE_LIT, 8'h10, 16'hF00F, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h20, 16'h0FF0, 0, 0, 0, 0, ERR_NONE);
      add_row(0, 0, MODE_LIT, 8'h30, 16'hFFFF, 1, 1, 8'h30, 1, ERR_NONE);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].set_len)
            set_file_length(dir_rows[i].new_len);
         send_request(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases: short files, mid files (with one full drain midway), one file
      // past the history depth with a calm stretch, an endless file, tiny files.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin len = $urandom_range(48, 1);  count = 50;  noise = 12; longs = 0; end
            1: begin len = $urandom_range(700, 49); count = 50; noise = 12; longs = 0; end
            2: begin len = 32'd4200;  count = 260; noise = 0;  longs = 1; end
            3: begin len = 32'hFFFF_FFFF; count = 25; noise = 15; longs = 0; end
            default: begin len = $urandom_range(16, 1); count = 25; noise = 12; longs = 0; end
         endcase
         set_file_length(len);
         for (int n = 0; n < count; n++) begin
            calm = (ph == 2 && n >= 40 && n < 140);
            if (ph == 1 && n == 25)
               wait_drained();
            make_token(noise, longs, t);
            send_request(t, 1'b0, none);
            random_sent++;
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      $display("%0d requests (%0d directed, %0d random), %0d result bytes checked",
               dir_rows.size() + random_sent, dir_rows.size(), random_sent, bytes_checked);
      $display("%0d files completed, %0d error results, longest file %0d bytes",
               files_done, error_results, deepest_count);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
